[design/ljpf_pkg.sv]
// ============================================================================
// ljpf_pkg
// Types, constants and arithmetic step functions for the pair-force pipeline.
// ============================================================================
package ljpf_pkg;

    // Fraction bits of positions, registers and forces
    localparam int F = 16;

    // Configuration register indexes
    localparam int          CFG_IDX_W        = 3;
    localparam logic [2:0]  REG_EPSILON      = 3'd0;
    localparam logic [2:0]  REG_SIGMA        = 3'd1;
    localparam logic [2:0]  REG_HERTZ_STIFF  = 3'd2;
    localparam logic [2:0]  REG_PART_RADIUS  = 3'd3;
    localparam logic [2:0]  REG_WALL_RADIUS  = 3'd4;

    localparam logic [31:0] EPSILON_RST      = 32'd65536;
    localparam logic [31:0] SIGMA_RST        = 32'd655360;
    localparam logic [31:0] HERTZ_STIFF_RST  = 32'd655360000;
    localparam logic [31:0] PART_RADIUS_RST  = 32'd196608;
    localparam logic [31:0] WALL_RADIUS_RST  = 32'd3276800;

    // Saturation of intermediate products and of the force outputs
    localparam logic [63:0] CHAIN_CAP = 64'h4000_0000_0000_0000;
    localparam logic [63:0] POS_LIM   = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIM   = 64'h0000_8000_0000_0000;

    // Widths of the dividers and root units
    localparam int NRM_W = F + 1;                  // unit vector component
    localparam int QN_W  = 32 + F;                 // sigma / r quotient
    localparam int HR_W  = 2 * ((37 + F) / 2);     // Hertz overlap radicand
    localparam int FQ_W  = 48;                     // force magnitude quotient

    // Stage schedule
    localparam int S_SQ   = 0;                     // squares
    localparam int S_SUM  = 1;                     // sum of squares
    localparam int S_RT   = 2;                     // distance root, 33 steps
    localparam int S_R    = S_RT + 33;             // divider and overlap setup
    localparam int S_D0   = S_R + 1;               // first divider step
    localparam int N_HRT  = HR_W / 2;              // overlap root steps
    localparam int S_HP   = S_D0 + N_HRT;          // s * sqrt(s)
    localparam int S_HH   = S_HP + 3;              // stiffness * p
    localparam int S_C0   = S_D0 + QN_W;           // q power chain
    localparam int S_M    = S_C0 + 12;             // q12 - q6
    localparam int S_K    = S_M + 1;               // 12 eps * m
    localparam int S_L    = S_K + 3;               // lane product with n_i
    localparam int S_FI   = S_L + 3;               // force divider setup
    localparam int S_F0   = S_FI + 1;              // force divider steps
    localparam int NSTG   = S_F0 + FQ_W;           // pipeline steps

    typedef struct packed {
        logic                       func;
        logic [2:0][32:0]           d;
        logic [2:0][32:0]           ad;
        logic [2:0][65:0]           sq;
        logic [65:0]                rad;
        logic [35:0]                srem;
        logic [33:0]                r;
        logic [2:0][NRM_W-1:0]      nbits;
        logic [2:0][33:0]           nrem;
        logic [2:0][NRM_W-1:0]      nq;
        logic [QN_W-1:0]            qbits;
        logic [33:0]                qrem;
        logic [QN_W-1:0]            q;
        logic                       hpos;
        logic [HR_W-1:0]            hrad;
        logic [35:0]                hrem;
        logic [33:0]                hroot;
        logic [63:0]                hv;
        logic                       hclamp;
        logic [3:0][63:0]           hpp;
        logic [127:0]               hprod;
        logic [63:0]                q2;
        logic [63:0]                q3;
        logic [63:0]                q6;
        logic [63:0]                q12;
        logic [63:0]                cv;
        logic [63:0]                k;
        logic                       ljclamp;
        logic                       dneg;
        logic [3:0][63:0]           cpp;
        logic [127:0]               cprod;
        logic [2:0][3:0][63:0]      lpp;
        logic [2:0][127:0]          lprod;
        logic [2:0][63:0]           u;
        logic [2:0]                 uclamp;
        logic [2:0][FQ_W-1:0]       fbits;
        logic [2:0][33:0]           frem;
        logic [2:0][FQ_W-1:0]       fq;
        logic [2:0]                 fhuge;
    } pipe_t;

    typedef struct packed {
        logic [35:0] rem;
        logic [33:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [33:0] rem;
        logic        qb;
    } div_t;

    typedef struct packed {
        logic [63:0] val;
        logic        clamp;
    } cap_t;

    typedef struct packed {
        logic [47:0] val;
        logic        ovf;
    } pack_t;

    // One restoring square root step, two radicand bits in
    function automatic sqrt_t sqrt_step(input logic [35:0] rem, input logic [33:0] root,
                                        input logic [1:0] two);
        sqrt_t       res;
        logic [37:0] t;
        logic [37:0] trial;
        t     = {rem, two};
        trial = {2'b00, root, 2'b01};
        if (t >= trial)
        begin
            res.rem  = 36'(t - trial);
            res.root = {root[32:0], 1'b1};
        end
        else
        begin
            res.rem  = t[35:0];
            res.root = {root[32:0], 1'b0};
        end
        return res;
    endfunction

    // One restoring division step, one numerator bit in
    function automatic div_t div_step(input logic [33:0] rem, input logic nb,
                                      input logic [33:0] den);
        div_t        res;
        logic [34:0] t;
        t = {rem, nb};
        if (t >= {1'b0, den})
        begin
            res.rem = 34'(t - {1'b0, den});
            res.qb  = 1'b1;
        end
        else
        begin
            res.rem = t[33:0];
            res.qb  = 1'b0;
        end
        return res;
    endfunction

    // 64x64 product: four 32x32 partial products
    function automatic logic [3:0][63:0] mul_pp(input logic [63:0] a, input logic [63:0] b);
        logic [3:0][63:0] pp;
        pp[0] = a[31:0]  * b[31:0];
        pp[1] = a[31:0]  * b[63:32];
        pp[2] = a[63:32] * b[31:0];
        pp[3] = a[63:32] * b[63:32];
        return pp;
    endfunction

    function automatic logic [127:0] mul_sum(input logic [3:0][63:0] pp);
        return 128'(pp[0]) + (128'(pp[1]) << 32) + (128'(pp[2]) << 32)
               + (128'(pp[3]) << 64);
    endfunction

    // Drop fraction bits and clamp to the chain cap
    function automatic cap_t mul_cap(input logic [127:0] prod);
        cap_t         res;
        logic [127:0] t;
        t         = prod >> F;
        res.clamp = t > 128'(CHAIN_CAP);
        res.val   = res.clamp ? CHAIN_CAP : t[63:0];
        return res;
    endfunction

    // Sign and saturate one force component
    function automatic pack_t pack_force(input logic [63:0] mag, input logic neg,
                                         input logic huge);
        pack_t       res;
        logic [63:0] lim;
        logic [63:0] m;
        lim     = neg ? NEG_LIM : POS_LIM;
        m       = mag;
        res.ovf = 1'b0;
        if (huge || mag > lim)
        begin
            m       = lim;
            res.ovf = 1'b1;
        end
        res.val = neg ? 48'(64'd0 - m) : m[47:0];
        return res;
    endfunction

endpackage

[design/lennard_jones_pair_force.sv]
// ============================================================================
// lennard_jones_pair_force
// Fixed-point Lennard-Jones pair force and Hertz wall contact force pipeline.
// ============================================================================
// Usage:
//   Command channel: a pair (func, ax..az, bx..bz) is taken at a rising edge
//   with start high and busy low. busy stays low: the pipeline takes one pair
//   every cycle.
//   Result channel: done pulses for one cycle with fx, fy, fz, contact,
//   coincident and overflow. Results come out in command order, after
//   passing the chain of bit-serial root and divider stages: distance
//   root, sigma/r, power chain, force divide. The receiver cannot stall;
//   every result is presented exactly once.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
//   cfg_index selects epsilon, sigma, hertz_stiffness, particle_radius or
//   wall_radius; other indexes are ignored. Write only while no pair is in
//   flight.
//   Reset: rst_n low clears all pipeline valid bits and the done strobe and
//   restores the register defaults. Throughput is one pair per cycle.
// ============================================================================
module lennard_jones_pair_force (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [31:0] ax,
    input  logic [31:0] ay,
    input  logic [31:0] az,
    input  logic [31:0] bx,
    input  logic [31:0] by,
    input  logic [31:0] bz,
    output logic        done,
    output logic [47:0] fx,
    output logic [47:0] fy,
    output logic [47:0] fz,
    output logic        contact,
    output logic        coincident,
    output logic        overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ljpf_pkg::*;

    localparam int LAT = NSTG + 2;
    localparam logic [47:0] OUT_MAX = {1'b0, {47{1'b1}}};
    localparam logic [47:0] OUT_MIN = {1'b1, 47'd0};

    logic [31:0] epsilon_reg;
    logic [31:0] sigma_reg;
    logic [31:0] hertz_stiffness_reg;
    logic [31:0] particle_radius_reg;
    logic [31:0] wall_radius_reg;

    pipe_t st_reg  [0:NSTG];
    pipe_t st_next [0:NSTG-1];
    logic  vld_reg [0:NSTG];
    pipe_t in_next;

    logic        done_reg;
    logic [47:0] fx_reg;
    logic [47:0] fy_reg;
    logic [47:0] fz_reg;
    logic        contact_reg;
    logic        coincident_reg;
    logic        overflow_reg;

    logic [2:0][47:0] f_next;
    logic             contact_next;
    logic             coincident_next;
    logic             overflow_next;

    // Pipeline never blocks
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg         <= EPSILON_RST;
            sigma_reg           <= SIGMA_RST;
            hertz_stiffness_reg <= HERTZ_STIFF_RST;
            particle_radius_reg <= PART_RADIUS_RST;
            wall_radius_reg     <= WALL_RADIUS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EPSILON:     epsilon_reg         <= cfg_data;
                REG_SIGMA:       sigma_reg           <= cfg_data;
                REG_HERTZ_STIFF: hertz_stiffness_reg <= cfg_data;
                REG_PART_RADIUS: particle_radius_reg <= cfg_data;
                REG_WALL_RADIUS: wall_radius_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // One pipeline step; k picks the operation at elaboration
    function automatic pipe_t stage_fn(input int k, input pipe_t x);
        pipe_t       y;
        sqrt_t       sr;
        div_t        dr;
        cap_t        cr;
        logic [35:0] s_w;
        logic [63:0] lop;
        logic [63:0] fhi;
        y = x;
        if (k == S_SQ)
        begin
            for (int i = 0; i < 3; i++)
                y.sq[i] = 66'(x.ad[i]) * 66'(x.ad[i]);
        end
        else if (k == S_SUM)
        begin
            y.rad  = x.sq[0] + x.sq[1] + x.sq[2];
            y.srem = '0;
            y.r    = '0;
        end
        else if (k >= S_RT && k < S_R)
        begin
            sr     = sqrt_step(x.srem, x.r, x.rad[65:64]);
            y.srem = sr.rem;
            y.r    = sr.root;
            y.rad  = x.rad << 2;
        end
        else if (k == S_R)
        begin
            for (int i = 0; i < 3; i++)
            begin
                y.nbits[i] = {x.ad[i][0], {F{1'b0}}};
                y.nrem[i]  = {2'b00, x.ad[i][32:1]};
                y.nq[i]    = '0;
            end
            y.qbits   = {sigma_reg, {F{1'b0}}};
            y.qrem    = '0;
            y.q       = '0;
            s_w       = 36'(particle_radius_reg) - 36'(wall_radius_reg) + 36'(x.r);
            y.hpos    = !s_w[35] && (s_w != 36'd0);
            y.hrad    = y.hpos ? HR_W'({s_w[33:0], {F{1'b0}}}) : '0;
            y.hrem    = '0;
            y.hroot   = '0;
            y.hv      = 64'(s_w[33:0]);
            y.hclamp  = 1'b0;
            y.ljclamp = 1'b0;
        end
        else
        begin
            // unit vector dividers
            if (k >= S_D0 && k < S_D0 + NRM_W)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dr         = div_step(x.nrem[i], x.nbits[i][NRM_W-1], x.r);
                    y.nrem[i]  = dr.rem;
                    y.nq[i]    = {x.nq[i][NRM_W-2:0], dr.qb};
                    y.nbits[i] = x.nbits[i] << 1;
                end
            end
            // sigma / r
            if (k >= S_D0 && k < S_D0 + QN_W)
            begin
                dr      = div_step(x.qrem, x.qbits[QN_W-1], x.r);
                y.qrem  = dr.rem;
                y.q     = {x.q[QN_W-2:0], dr.qb};
                y.qbits = x.qbits << 1;
            end
            // sqrt of the wall overlap
            if (k >= S_D0 && k < S_D0 + N_HRT)
            begin
                sr      = sqrt_step(x.hrem, x.hroot, x.hrad[HR_W-1:HR_W-2]);
                y.hrem  = sr.rem;
                y.hroot = sr.root;
                y.hrad  = x.hrad << 2;
            end
            // Hertz chain: p = s * sqrt(s), then h = stiffness * p
            if (k == S_HP)
                y.hpp = mul_pp(x.hv, 64'(x.hroot));
            if (k == S_HH)
                y.hpp = mul_pp(64'(hertz_stiffness_reg), x.hv);
            if (k == S_HP + 1 || k == S_HH + 1)
                y.hprod = mul_sum(x.hpp);
            if (k == S_HP + 2 || k == S_HH + 2)
            begin
                cr       = mul_cap(x.hprod);
                y.hv     = cr.val;
                y.hclamp = x.hclamp | cr.clamp;
            end
            // LJ power chain and k
            if (k == S_C0)
                y.cpp = mul_pp(64'(x.q), 64'(x.q));
            if (k == S_C0 + 3)
                y.cpp = mul_pp(x.q2, 64'(x.q));
            if (k == S_C0 + 6)
                y.cpp = mul_pp(x.q3, x.q3);
            if (k == S_C0 + 9)
                y.cpp = mul_pp(x.q6, x.q6);
            if (k == S_K)
                y.cpp = mul_pp(x.cv, x.k);
            if (k == S_C0 + 1 || k == S_C0 + 4 || k == S_C0 + 7 || k == S_C0 + 10
                || k == S_K + 1)
                y.cprod = mul_sum(x.cpp);
            cr = mul_cap(x.cprod);
            if (k == S_C0 + 2)
                y.q2 = cr.val;
            if (k == S_C0 + 5)
                y.q3 = cr.val;
            if (k == S_C0 + 8)
                y.q6 = cr.val;
            if (k == S_C0 + 11)
                y.q12 = cr.val;
            if (k == S_K + 2)
                y.k = cr.val;
            if (k == S_C0 + 2 || k == S_C0 + 5 || k == S_C0 + 8 || k == S_C0 + 11
                || k == S_K + 2)
                y.ljclamp = x.ljclamp | cr.clamp;
            // difference of powers, direction, 12 * epsilon
            if (k == S_M)
            begin
                y.dneg = (x.q12 < x.q6) && !x.ljclamp;
                y.k    = (x.q12 >= x.q6) ? x.q12 - x.q6 : x.q6 - x.q12;
                y.cv   = (64'(epsilon_reg) << 3) + (64'(epsilon_reg) << 2);
            end
            // per-axis product with the unit vector
            lop = x.func ? x.hv : x.k;
            for (int i = 0; i < 3; i++)
            begin
                if (k == S_L)
                    y.lpp[i] = mul_pp(lop, 64'(x.nq[i]));
                if (k == S_L + 1)
                    y.lprod[i] = mul_sum(x.lpp[i]);
                if (k == S_L + 2)
                begin
                    cr          = mul_cap(x.lprod[i]);
                    y.u[i]      = cr.val;
                    y.uclamp[i] = cr.clamp;
                end
                // force divide by r: overflow check on the top part first
                if (k == S_FI)
                begin
                    fhi        = x.u[i] >> (FQ_W - F);
                    y.fhuge[i] = fhi >= 64'(x.r);
                    y.frem[i]  = y.fhuge[i] ? 34'd0 : fhi[33:0];
                    y.fbits[i] = {x.u[i][FQ_W-F-1:0], {F{1'b0}}};
                    y.fq[i]    = '0;
                end
                if (k >= S_F0 && k < S_F0 + FQ_W)
                begin
                    dr         = div_step(x.frem[i], x.fbits[i][FQ_W-1], x.r);
                    y.frem[i]  = dr.rem;
                    y.fq[i]    = {x.fq[i][FQ_W-2:0], dr.qb};
                    y.fbits[i] = x.fbits[i] << 1;
                end
            end
        end
        return y;
    endfunction

    // Input stage: displacement and its magnitude per axis
    always_comb
    begin
        in_next      = '0;
        in_next.func = func;
        in_next.d[0] = {bx[31], bx} - {ax[31], ax};
        in_next.d[1] = {by[31], by} - {ay[31], ay};
        in_next.d[2] = {bz[31], bz} - {az[31], az};
        for (int i = 0; i < 3; i++)
            in_next.ad[i] = in_next.d[i][32] ? (~in_next.d[i] + 33'd1) : in_next.d[i];
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= in_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= start && !busy;
    end

    // Pipeline stages
    for (genvar g = 0; g < NSTG; g++)
    begin : g_stage
        always_comb
        begin
            st_next[g] = stage_fn(g, st_reg[g]);
        end

        always_ff @(posedge clk)
        begin
            st_reg[g+1] <= st_next[g];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g+1] <= 1'b0;
            else
                vld_reg[g+1] <= vld_reg[g];
        end
    end

    // Sign, saturation and special cases
    always_comb
    begin
        pipe_t       x;
        pack_t       pk;
        logic        cum;
        logic        act;
        logic        neg;
        logic        huge;
        logic [63:0] mag;
        x               = st_reg[NSTG];
        cum             = 1'b0;
        overflow_next   = 1'b0;
        coincident_next = (x.r == 34'd0);
        contact_next    = x.func ? x.hpos : 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cum = cum | x.uclamp[i];
            if (!x.func)
            begin
                act  = (x.r != 34'd0) && (x.nq[i] != '0);
                mag  = 64'(x.fq[i]);
                neg  = x.dneg ? x.d[i][32] : (!x.d[i][32] && x.d[i] != 33'd0);
                huge = x.ljclamp | cum | x.fhuge[i];
            end
            else
            begin
                act  = x.hpos && (x.r != 34'd0) && (x.nq[i] != '0);
                mag  = x.u[i];
                neg  = x.d[i][32];
                huge = x.hclamp | cum;
            end
            pk            = pack_force(mag, neg, huge);
            f_next[i]     = act ? pk.val : 48'd0;
            overflow_next = overflow_next | (act & pk.ovf);
        end
    end

    // Result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        fx_reg         <= f_next[0];
        fy_reg         <= f_next[1];
        fz_reg         <= f_next[2];
        contact_reg    <= contact_next;
        coincident_reg <= coincident_next;
        overflow_reg   <= overflow_next;
    end

    assign done       = done_reg;
    assign fx         = fx_reg;
    assign fy         = fy_reg;
    assign fz         = fz_reg;
    assign contact    = contact_reg;
    assign coincident = coincident_reg;
    assign overflow   = overflow_reg;

    // Checks
    a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && coincident |-> fx == 48'd0 && fy == 48'd0 && fz == 48'd0)
        else $error("coincident pair with nonzero force");

    a_no_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !contact |-> fx == 48'd0 && fy == 48'd0 && fz == 48'd0)
        else $error("force without contact");

    a_overflow_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |-> fx == OUT_MAX || fx == OUT_MIN || fy == OUT_MAX
        || fy == OUT_MIN || fz == OUT_MAX || fz == OUT_MIN)
        else $error("overflow flagged with no saturated component");

    a_done_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching command");

endmodule

[verif/lennard_jones_pair_force_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// lennard_jones_pair_force_tb
// Self-checking bench for the pair-force pipeline: directed table of pairs,
// then random LJ and Hertz pairs over several register settings, each result
// compared against a hand-written result or a bit-exact fixed-point force predictor.
// ============================================================================
module lennard_jones_pair_force_tb;
    import ljpf_pkg::*;

    localparam int LATENCY   = NSTG + 1;
    localparam int N_RANDOM  = 800;
    localparam int CYCLE_LIM = 400000;

    typedef struct {
        logic        func;
        logic [31:0] a [3];
        logic [31:0] b [3];
    } pair_t;

    typedef struct {
        logic [47:0] f [3];
        logic        contact;
        logic        coincident;
        logic        overflow;
    } force_t;

    // Directed row: the pair and optionally a hand-written result
    typedef struct {
        pair_t  p;
        logic   known;
        force_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        func;
    logic [31:0] ax, ay, az, bx, by, bz;
    logic        done;
    logic [47:0] fx, fy, fz;
    logic        contact, coincident, overflow;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // Predictor copy of the registers
    logic [63:0] eps_r, sig_r, stiff_r, prad_r, wrad_r;

    force_t      force_q [$];
    int          errors;
    int          n_results;
    int          n_lj, n_hertz, n_ovf, n_coinc;
    longint      cycles;

    lennard_jones_pair_force u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .ax         (ax),
        .ay         (ay),
        .az         (az),
        .bx         (bx),
        .by         (by),
        .bz         (bz),
        .done       (done),
        .fx         (fx),
        .fy         (fy),
        .fz         (fz),
        .contact    (contact),
        .coincident (coincident),
        .overflow   (overflow),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Fixed-point helpers
    function automatic logic [63:0] cap_mul(input logic [63:0] x, input logic [63:0] y,
                                            inout logic clamp);
        logic [127:0] p;
        p = ({64'd0, x} * {64'd0, y}) >> F;
        if (p > 128'(CHAIN_CAP))
        begin
            clamp = 1'b1;
            return CHAIN_CAP;
        end
        return p[63:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] v);
        logic [63:0]  res;
        logic [63:0]  c;
        res = 0;
        for (int i = 35; i >= 0; i--)
        begin
            c = res | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= v)
                res = c;
        end
        return res;
    endfunction

    function automatic logic [47:0] sign_sat(input logic [63:0] mag, input logic neg,
                                             input logic huge, inout logic ovf);
        logic [63:0] lim;
        lim = neg ? NEG_LIM : POS_LIM;
        if (huge || mag > lim)
        begin
            mag = lim;
            ovf = 1'b1;
        end
        return neg ? 48'(64'd0 - mag) : mag[47:0];
    endfunction

    // Expected force for one pair under the current registers
    function automatic force_t pair_force(input pair_t p);
        force_t       o;
        logic signed [63:0] d [3];
        logic [63:0]  ad [3];
        logic [63:0]  nrm [3];
        logic [127:0] sum;
        logic [63:0]  r, q, q2, q3, q6, q12, m, k, u, rt, pw, h;
        logic [127:0] fw;
        logic signed [63:0] s;
        logic         clamp, ovf, dneg, neg;
        sum   = 0;
        clamp = 0;
        ovf   = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i]  = 64'(signed'(p.b[i])) - 64'(signed'(p.a[i]));
            ad[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
            sum  += {64'd0, ad[i]} * {64'd0, ad[i]};
            o.f[i] = 0;
        end
        r = root_floor(sum);
        o.coincident = (r == 0);
        o.contact    = 0;
        for (int i = 0; i < 3; i++)
            nrm[i] = r != 0 ? (ad[i] << F) / r : 0;
        if (!p.func)
        begin
            o.contact = 1;
            if (r != 0)
            begin
                q    = (sig_r << F) / r;
                q2   = cap_mul(q, q, clamp);
                q3   = cap_mul(q2, q, clamp);
                q6   = cap_mul(q3, q3, clamp);
                q12  = cap_mul(q6, q6, clamp);
                dneg = q12 < q6 && !clamp;
                m    = q12 >= q6 ? q12 - q6 : q6 - q12;
                k    = cap_mul(64'd12 * eps_r, m, clamp);
                for (int i = 0; i < 3; i++)
                    if (nrm[i] != 0)
                    begin
                        u  = cap_mul(k, nrm[i], clamp);
                        fw = ({64'd0, u} << F) / {64'd0, r};
                        neg = dneg ? d[i] < 0 : d[i] > 0;
                        o.f[i] = sign_sat(fw[63:0], neg, clamp || fw[127:64] != 0, ovf);
                    end
            end
        end
        else
        begin
            s = signed'(prad_r) - signed'(wrad_r) + signed'(r);
            if (s > 0)
            begin
                o.contact = 1;
                if (r != 0)
                begin
                    rt = root_floor({64'd0, 64'(s) << F});
                    pw = cap_mul(64'(s), rt, clamp);
                    h  = cap_mul(stiff_r, pw, clamp);
                    for (int i = 0; i < 3; i++)
                        if (nrm[i] != 0)
                        begin
                            u = cap_mul(h, nrm[i], clamp);
                            o.f[i] = sign_sat(u, d[i] < 0, clamp, ovf);
                        end
                end
            end
        end
        o.overflow = ovf;
        return o;
    endfunction

    // Issue one pair; expectation is queued at the accepting edge
    task automatic send_pair(input pair_t p, input logic known, input force_t res);
        start = 1'b1;
        func  = p.func;
        ax = p.a[0]; ay = p.a[1]; az = p.a[2];
        bx = p.b[0]; by = p.b[1]; bz = p.b[2];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        force_q.push_back(known ? res : pair_force(p));
        if (p.func) n_hertz++; else n_lj++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        repeat (n) @(negedge clk);
    endtask

    // Wait until every expected result has arrived, plus pipeline drain
    task automatic drain();
        while (force_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_EPSILON:     eps_r   = {32'd0, val};
            REG_SIGMA:       sig_r   = {32'd0, val};
            REG_HERTZ_STIFF: stiff_r = {32'd0, val};
            REG_PART_RADIUS: prad_r  = {32'd0, val};
            REG_WALL_RADIUS: wrad_r  = {32'd0, val};
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
            default: return 32'($urandom_range(0, 32'h0000_4000)) - 32'h0000_2000;
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int    mode;
        mode   = $urandom_range(0, 5);
        mode   = mode == 0 ? 0 : (mode < 4 ? 1 : 2);
        p.func = $urandom_range(0, 1);
        for (int i = 0; i < 3; i++)
        begin
            p.a[i] = rand_coord(mode);
            p.b[i] = $urandom_range(0, 7) == 0 ? p.a[i] : rand_coord(mode);
        end
        return p;
    endfunction

    function automatic pair_t mk(input logic fn, input logic [31:0] a0, input logic [31:0] a1,
                                 input logic [31:0] a2, input logic [31:0] b0,
                                 input logic [31:0] b1, input logic [31:0] b2);
        pair_t p;
        p.func = fn;
        p.a[0] = a0; p.a[1] = a1; p.a[2] = a2;
        p.b[0] = b0; p.b[1] = b1; p.b[2] = b2;
        return p;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            force_t e;
            if (force_q.size() == 0)
            begin
                $display("%0t: result with nothing expected", $realtime);
                errors <= errors + 1;
            end
            else
            begin
                e = force_q.pop_front();
                n_results <= n_results + 1;
                if (overflow) n_ovf <= n_ovf + 1;
                if (coincident) n_coinc <= n_coinc + 1;
                if (fx !== e.f[0] || fy !== e.f[1] || fz !== e.f[2]
                    || contact !== e.contact || coincident !== e.coincident
                    || overflow !== e.overflow)
                begin
                    $display("%0t: mismatch exp f=%h %h %h c=%b z=%b o=%b", $realtime,
                             e.f[0], e.f[1], e.f[2], e.contact, e.coincident, e.overflow);
                    $display("%0t:          got f=%h %h %h c=%b z=%b o=%b", $realtime,
                             fx, fy, fz, contact, coincident, overflow);
                    errors <= errors + 1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIM)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        row_t   rows [$];
        row_t   rw;
        force_t zero_coinc;
        logic [31:0] cfgs [5][3];
        rst_n = 1'b0; start = 1'b0; func = 1'b0;
        ax = 0; ay = 0; az = 0; bx = 0; by = 0; bz = 0;
        cfg_valid = 1'b0; cfg_index = REG_EPSILON; cfg_data = 0;
        errors = 0; n_results = 0; n_lj = 0; n_hertz = 0; n_ovf = 0; n_coinc = 0;
        cycles = 0;
        eps_r = 64'(EPSILON_RST); sig_r = 64'(SIGMA_RST); stiff_r = 64'(HERTZ_STIFF_RST);
        prad_r = 64'(PART_RADIUS_RST); wrad_r = 64'(WALL_RADIUS_RST);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: coincident pairs have an obvious result
        zero_coinc.f[0] = 0; zero_coinc.f[1] = 0; zero_coinc.f[2] = 0;
        zero_coinc.contact = 1; zero_coinc.coincident = 1; zero_coinc.overflow = 0;
        rw.known = 1; rw.res = zero_coinc;
        rw.p = mk(0, 0, 0, 0, 0, 0, 0); rows.push_back(rw);
        rw.p = mk(0, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678,
                  32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678); rows.push_back(rw);
        // Hertz, zero distance: no overlap with reset radii
        rw.res.contact = 0;
        rw.p = mk(1, 5, 6, 7, 5, 6, 7); rows.push_back(rw);
        rw.known = 0;
        // LJ at, inside and outside sigma, each axis and sign
        rw.p = mk(0, 0, 0, 0, 32'h000a_0000, 0, 0); rows.push_back(rw);
        rw.p = mk(0, 0, 0, 0, 0, 32'hfffb_0000, 0); rows.push_back(rw);
        rw.p = mk(0, 0, 0, 0, 0, 0, 32'h0020_0000); rows.push_back(rw);
        rw.p = mk(0, 0, 0, 0, 1, 0, 0); rows.push_back(rw);
        rw.p = mk(0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000); rows.push_back(rw);
        rw.p = mk(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff); rows.push_back(rw);
        rw.p = mk(0, 32'h7fff_ffff, 0, 32'h8000_0000,
                  32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff); rows.push_back(rw);
        // Hertz: inside, at and beyond contact, extreme span
        rw.p = mk(1, 0, 0, 0, 32'h0028_0000, 0, 0); rows.push_back(rw);
        rw.p = mk(1, 0, 0, 0, 32'h002f_0000, 0, 0); rows.push_back(rw);
        rw.p = mk(1, 0, 0, 0, 32'h0030_0000, 32'h0001_0000, 0); rows.push_back(rw);
        rw.p = mk(1, 0, 0, 0, 0, 32'hffc0_0000, 32'h0010_0000); rows.push_back(rw);
        rw.p = mk(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff); rows.push_back(rw);
        rw.p = mk(1, 32'h1000_0000, 32'hf000_0000, 0, 0, 0, 32'h4000_0000); rows.push_back(rw);
        foreach (rows[i])
        begin
            send_pair(rows[i].p, rows[i].known, rows[i].res);
            if (i % 3 == 0)
                idle_gap();
        end
        drain();

        // Register settings: typical, small, extremes
        cfgs[0] = '{EPSILON_RST, 32'h0000_0001, 32'h0001_0000};
        cfgs[1] = '{SIGMA_RST, 32'h0000_0000, 32'hffff_ffff};
        cfgs[2] = '{HERTZ_STIFF_RST, 32'h0000_0000, 32'hffff_ffff};
        cfgs[3] = '{PART_RADIUS_RST, 32'hffff_ffff, 32'h0000_0000};
        cfgs[4] = '{WALL_RADIUS_RST, 32'h0000_0000, 32'hffff_ffff};
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                for (int r = 0; r < 5; r++)
                    write_reg(3'(r), ph < 3 ? cfgs[r][ph] : $urandom);
                // out-of-range index must be ignored
                write_reg(3'd7, $urandom);
            end
            for (int n = 0; n < N_RANDOM / 6; n++)
            begin
                send_pair(rand_pair(), 0, zero_coinc);
                idle_gap();
                // hold off once until the pipe is empty
                if (ph == 1 && n == 40)
                    drain();
            end
        end
        drain();
        repeat (LATENCY + 10) @(negedge clk);

        $display("covered %0d LJ and %0d Hertz pairs over 6 register settings", n_lj, n_hertz);
        $display("%0d results, %0d saturated, %0d coincident", n_results, n_ovf, n_coinc);
        if (errors == 0 && force_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
